@@ src/s2i_pkg.sv @@
// s2i_pkg: shared types, constants and helpers of the string to integer parser
// used by every module of the block; no dependencies
package s2i_pkg;

	localparam int CH_W    = 8;
	localparam int RADIX_W = 6;
	localparam int CNT_W   = 16;
	localparam int VALUE_W = 64;
	localparam int PROD_W  = VALUE_W + RADIX_W;
	localparam int SUM_W   = PROD_W + 1;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_RADIX = 3'd0;

	// radix codes
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
	localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
	localparam logic [RADIX_W-1:0] RADIX_TWO   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_LIMIT = 6'd36;

	// digit value of a character that is neither a digit nor a letter
	localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

	localparam logic [CNT_W-1:0]   MAX_CHARS = 16'hFFFF;
	localparam logic [VALUE_W-1:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] NEG_MAG   = 64'h8000_0000_0000_0000;

	// characters
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CH_W-1:0] LETTER_BASE = 8'd10;

	// queue sizes
	localparam int INQ_DEPTH  = 4;
	localparam int INQ_AW     = $clog2(INQ_DEPTH);
	localparam int OUTQ_DEPTH = 2;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGN,
		PH_PFX0,
		PH_PFXX,
		PH_DIG,
		PH_DONE
	} phase_t;

	// classified character handed from front to back
	typedef struct packed {
		logic [RADIX_W-1:0] digit;
		logic               is_ws;
		logic               is_sign;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               first;
		logic               last;
	} char_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   end_offset;
		logic               overflowed;
	} result_t;

	// digit or letter value, DIGIT_NONE for anything else
	function automatic logic [RADIX_W-1:0] digit_of(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] d;
		d = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			return d[RADIX_W-1:0];
		end
		if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d = c - CH_LO_A + LETTER_BASE;
			return d[RADIX_W-1:0];
		end
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d = c - CH_UP_A + LETTER_BASE;
			return d[RADIX_W-1:0];
		end
		return DIGIT_NONE;
	endfunction

	// character count, sticks at its maximum
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		if (c == MAX_CHARS) begin
			return c;
		end
		return c + 1'b1;
	endfunction

	function automatic logic bad_radix(input logic [RADIX_W-1:0] r);
		return (r == RADIX_ONE) || (r > RADIX_LIMIT);
	endfunction

endpackage

@@ src/s2i_front.sv @@
// s2i_front: accepts characters, classifies them and queues them for the back end
// depends on s2i_pkg
module s2i_front
	import s2i_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CH_W-1:0]  ch,
	input  logic             first,
	input  logic             last,
	input  logic             push,
	output logic             full,
	output char_item_t       item,
	output logic             item_valid,
	input  logic             item_take
);

	logic [INQ_AW:0]   cnt_q;
	logic [INQ_AW-1:0] wr_q;
	logic [INQ_AW-1:0] rd_q;
	char_item_t        mem_q [INQ_DEPTH];
	char_item_t        cls;
	logic              wr_en;
	logic              rd_en;

	// character classification
	always_comb begin
		cls.digit    = digit_of(ch);
		cls.is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
		cls.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
		cls.is_minus = (ch == CH_MINUS);
		cls.is_zero  = (ch == CH_ZERO);
		cls.is_x     = (ch == CH_LO_X) || (ch == CH_UP_X);
		cls.first    = first;
		cls.last     = last;
	end

	assign full       = (cnt_q == (INQ_AW+1)'(INQ_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign wr_en      = push && !full;
	assign rd_en      = item_take && item_valid;
	assign item       = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= cls;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/s2i_back.sv @@
// s2i_back: scan state, digit accumulation with overflow check, and result queue
// depends on s2i_pkg
module s2i_back
	import s2i_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RADIX_W-1:0] radix,
	input  char_item_t         item,
	input  logic               item_valid,
	output logic               item_take,
	input  logic               pop,
	output logic               empty,
	output result_t            res
);

	phase_t             phase_q;
	logic               neg_q;
	logic [VALUE_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RADIX_W-1:0] ar_q;

	phase_t             ph;
	logic               neg;
	logic [VALUE_W-1:0] acc;
	logic [CNT_W-1:0]   cnt;
	logic [RADIX_W-1:0] ar;
	logic               stop;
	logic               fire;
	result_t            res_v;
	logic [PROD_W-1:0]  mul;
	logic [SUM_W-1:0]   sum;
	logic [VALUE_W-1:0] lim;

	result_t            oq_q [OUTQ_DEPTH];
	logic [OUTQ_AW:0]   ocnt_q;
	logic [OUTQ_AW-1:0] owr_q;
	logic [OUTQ_AW-1:0] ord_q;
	logic               pop_fire;
	logic               room;
	logic               step;
	logic               opush;

	// one character through the scan phases
	always_comb begin
		ph    = phase_q;
		neg   = neg_q;
		acc   = acc_q;
		cnt   = cnt_q;
		ar    = ar_q;
		stop  = 1'b0;
		fire  = 1'b0;
		res_v = '0;
		mul   = '0;
		sum   = '0;
		lim   = '0;
		if (item.first) begin
			ph  = PH_WS;
			neg = 1'b0;
			acc = '0;
			cnt = '0;
			ar  = '0;
		end
		if (ph != PH_DONE) begin
			// leading whitespace, radix latched here
			if (ph == PH_WS) begin
				ar = radix;
				if (bad_radix(ar)) begin
					fire = 1'b1;
					stop = 1'b1;
					ph   = PH_DONE;
				end else if (item.is_ws) begin
					cnt  = sat_inc(cnt);
					stop = 1'b1;
				end else begin
					ph = PH_SIGN;
				end
			end
			// optional sign
			if (!stop && ph == PH_SIGN) begin
				ph = (ar == RADIX_AUTO) ? PH_PFX0 : PH_DIG;
				if (item.is_sign) begin
					neg  = item.is_minus;
					cnt  = sat_inc(cnt);
					stop = 1'b1;
				end
			end
			// leading zero of an automatic prefix
			if (!stop && ph == PH_PFX0) begin
				if (item.is_zero) begin
					cnt  = sat_inc(cnt);
					ph   = PH_PFXX;
					stop = 1'b1;
				end else begin
					ar = RADIX_DEC;
					ph = PH_DIG;
				end
			end
			// x after the leading zero
			if (!stop && ph == PH_PFXX) begin
				ph = PH_DIG;
				if (item.is_x) begin
					cnt  = sat_inc(cnt);
					ar   = RADIX_HEX;
					stop = 1'b1;
				end else begin
					ar = RADIX_OCT;
				end
			end
			// digit multiply-add with range check
			if (!stop && ph == PH_DIG) begin
				lim = neg ? NEG_MAG : POS_MAX;
				mul = {{RADIX_W{1'b0}}, acc} * {{VALUE_W{1'b0}}, ar};
				sum = {1'b0, mul} + {{(SUM_W-RADIX_W){1'b0}}, item.digit};
				if (ar < RADIX_TWO || item.digit >= ar) begin
					fire             = 1'b1;
					res_v.value      = neg ? (VALUE_W'(0) - acc) : acc;
					res_v.end_offset = cnt;
					ph               = PH_DONE;
				end else if (sum > {{(SUM_W-VALUE_W){1'b0}}, lim}) begin
					fire             = 1'b1;
					res_v.value      = neg ? NEG_MAG : POS_MAX;
					res_v.overflowed = 1'b1;
					ph               = PH_DONE;
				end else begin
					acc = sum[VALUE_W-1:0];
					cnt = sat_inc(cnt);
				end
			end
			// end of string closes an open scan
			if (!fire && item.last) begin
				fire = 1'b1;
				if ((ph == PH_WS || ph == PH_SIGN) && bad_radix(radix)) begin
					res_v = '0;
				end else begin
					res_v.value      = neg ? (VALUE_W'(0) - acc) : acc;
					res_v.end_offset = cnt;
				end
				ph = PH_DONE;
			end
		end
	end

	assign empty     = (ocnt_q == '0);
	assign pop_fire  = pop && !empty;
	assign room      = (ocnt_q != (OUTQ_AW+1)'(OUTQ_DEPTH)) || pop_fire;
	assign step      = item_valid && room;
	assign item_take = step;
	assign opush     = step && fire;
	assign res       = oq_q[ord_q];

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= '0;
			ar_q    <= '0;
		end else if (step) begin
			phase_q <= ph;
			neg_q   <= neg;
			acc_q   <= acc;
			cnt_q   <= cnt;
			ar_q    <= ar;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (opush) begin
			oq_q[owr_q] <= res_v;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
			owr_q  <= '0;
			ord_q  <= '0;
		end else begin
			if (opush) begin
				owr_q <= owr_q + 1'b1;
			end
			if (pop_fire) begin
				ord_q <= ord_q + 1'b1;
			end
			if (opush && !pop_fire) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (pop_fire && !opush) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/string_to_integer_parser_unit.sv @@
// string_to_integer_parser_unit: top level with the radix register
// depends on s2i_pkg, s2i_front, s2i_back
//
// Usage:
// Characters enter one per transfer on the input queue port (push/full) with
// first marking the start of a string and last its final character. Results
// leave on the output queue port (empty/pop): value, end_offset, overflowed;
// a string gives one result at its first rejected character, at its last
// character, on overflow or on a bad radix.
// The radix register sits at byte address 0 of the APB port (reset 10, 0 for
// prefix detection); write it only while no string is in flight.
// Throughput: one character per cycle while the result queue has room, set
// by the single 64x6 multiply-add of the back end. A result is registered in
// the input queue and then in the result queue before it shows on the output,
// later if the queues hold older items.
// A four-entry queue separates the classifier from the scan engine and a
// two-entry queue holds results; when pop stays low the result queue fills,
// the scan stops, and full rises once the input queue is full.
// Reset clears both queues, the scan state and sets the radix to 10.
module string_to_integer_parser_unit
	import s2i_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready,
	input  logic [CH_W-1:0]           ch,
	input  logic                      first,
	input  logic                      last,
	input  logic                      push,
	output logic                      full,
	output logic signed [VALUE_W-1:0] value,
	output logic [CNT_W-1:0]          end_offset,
	output logic                      overflowed,
	output logic                      empty,
	input  logic                      pop
);

	logic [RADIX_W-1:0] radix_q;
	char_item_t         item;
	logic               item_valid;
	logic               item_take;
	result_t            res;
	logic               reg_wr;

	// configuration register
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr == ADDR_RADIX);
	assign prdata = (paddr == ADDR_RADIX) ? {{(PDATA_W-RADIX_W){1'b0}}, radix_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (reg_wr) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	s2i_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch         (ch),
		.first      (first),
		.last       (last),
		.push       (push),
		.full       (full),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	s2i_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix      (radix_q),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	// result ports
	assign value      = res.value;
	assign end_offset = res.end_offset;
	assign overflowed = res.overflowed;

endmodule

@@ src/s2i_checker.sv @@
// s2i_checker: port-level assertions of the parser, bound to the top level
// depends on s2i_pkg and string_to_integer_parser_unit
module s2i_checker
	import s2i_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      psel,
	input logic                      penable,
	input logic                      pwrite,
	input logic [PADDR_W-1:0]        paddr,
	input logic [PDATA_W-1:0]        pwdata,
	input logic [PDATA_W-1:0]        prdata,
	input logic signed [VALUE_W-1:0] value,
	input logic [CNT_W-1:0]          end_offset,
	input logic                      overflowed,
	input logic                      empty,
	input logic                      pop
);

	// an overflow result reports no consumed characters
	a_ovf_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && overflowed) |-> (end_offset == '0))
		else $error("overflow result with nonzero end_offset");

	// an overflow result is saturated
	a_ovf_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && overflowed) |-> (value == POS_MAX || value == NEG_MAG))
		else $error("overflow result not saturated");

	// a waiting result holds until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(value) && $stable(end_offset)))
		else $error("result changed while stalled");

	// radix readback follows the last write
	a_radix_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == ADDR_RADIX) |=>
		(paddr != ADDR_RADIX || prdata[RADIX_W-1:0] == $past(pwdata[RADIX_W-1:0])))
		else $error("radix readback mismatch");

endmodule

bind string_to_integer_parser_unit s2i_checker u_s2i_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata),
	.value      (value),
	.end_offset (end_offset),
	.overflowed (overflowed),
	.empty      (empty),
	.pop        (pop)
);

@@ dv/s2i_result_checker.sv @@
// s2i_result_checker: watches the character, result and register ports of the parser,
// predicts every result and compares it field by field
// depends on s2i_pkg
module s2i_result_checker
	import s2i_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	input  logic [CH_W-1:0]           ch,
	input  logic                      first,
	input  logic                      last,
	input  logic                      push,
	input  logic                      full,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [CNT_W-1:0]          end_offset,
	input  logic                      overflowed,
	input  logic                      empty,
	input  logic                      pop,
	output int                        fail_count,
	output int                        open_results
);

	localparam int NOT_DIGIT = 99;

	// shadow of the radix register and of the scan state
	logic [RADIX_W-1:0] radix_reg;
	phase_t             scan_phase;
	logic               scan_neg;
	logic [VALUE_W-1:0] scan_mag;
	logic [CNT_W-1:0]   scan_cnt;
	logic [RADIX_W-1:0] scan_radix;

	result_t parsed_q[$];
	int      mismatches;

	function automatic int char_value(input logic [CH_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			return int'(c) - int'(CH_ZERO);
		end
		if (c >= CH_LO_A && c <= CH_LO_Z) begin
			return int'(c) - int'(CH_LO_A) + 10;
		end
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			return int'(c) - int'(CH_UP_A) + 10;
		end
		return NOT_DIGIT;
	endfunction

	function automatic bit is_blank(input logic [CH_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic bit radix_invalid(input logic [RADIX_W-1:0] r);
		return r == RADIX_ONE || r > RADIX_LIMIT;
	endfunction

	task automatic reset_scan();
		scan_phase = PH_WS;
		scan_neg   = 1'b0;
		scan_mag   = '0;
		scan_cnt   = '0;
		scan_radix = '0;
	endtask

	// consumed characters stick at the maximum count
	task automatic count_char();
		if (scan_cnt != MAX_CHARS) begin
			scan_cnt++;
		end
	endtask

	task automatic close_scan(input logic [VALUE_W-1:0] v, input logic [CNT_W-1:0] off,
			input logic ovf);
		result_t r;
		r.value      = v;
		r.end_offset = off;
		r.overflowed = ovf;
		parsed_q.push_back(r);
		scan_phase = PH_DONE;
	endtask

	task automatic close_normal();
		close_scan(scan_neg ? -scan_mag : scan_mag, scan_cnt, 1'b0);
	endtask

	// one character through the scan; a phase may hand it on to the next phase
	task automatic take_char(input logic [CH_W-1:0] c, output bit emitted);
		bit                 busy;
		int                 d;
		logic [VALUE_W-1:0] lim;
		logic [VALUE_W-1:0] r64;
		emitted = 1'b0;
		busy    = 1'b1;
		while (busy) begin
			busy = 1'b0;
			case (scan_phase)
				PH_WS: begin
					scan_radix = radix_reg;
					if (radix_invalid(scan_radix)) begin
						close_scan('0, '0, 1'b0);
						emitted = 1'b1;
					end else if (is_blank(c)) begin
						count_char();
					end else begin
						scan_phase = PH_SIGN;
						busy       = 1'b1;
					end
				end
				PH_SIGN: begin
					scan_phase = (scan_radix == RADIX_AUTO) ? PH_PFX0 : PH_DIG;
					if (c == CH_MINUS || c == CH_PLUS) begin
						scan_neg = (c == CH_MINUS);
						count_char();
					end else begin
						busy = 1'b1;
					end
				end
				PH_PFX0: begin
					if (c == CH_ZERO) begin
						count_char();
						scan_phase = PH_PFXX;
					end else begin
						scan_radix = RADIX_DEC;
						scan_phase = PH_DIG;
						busy       = 1'b1;
					end
				end
				PH_PFXX: begin
					scan_phase = PH_DIG;
					if (c == CH_LO_X || c == CH_UP_X) begin
						count_char();
						scan_radix = RADIX_HEX;
					end else begin
						scan_radix = RADIX_OCT;
						busy       = 1'b1;
					end
				end
				PH_DIG: begin
					d   = char_value(c);
					lim = scan_neg ? NEG_MAG : POS_MAX;
					r64 = VALUE_W'(scan_radix);
					if (scan_radix < RADIX_TWO || d >= int'(scan_radix)) begin
						close_normal();
						emitted = 1'b1;
					end else if (scan_mag > (lim - VALUE_W'(d)) / r64) begin
						close_scan(scan_neg ? NEG_MAG : POS_MAX, '0, 1'b1);
						emitted = 1'b1;
					end else begin
						scan_mag = scan_mag * r64 + VALUE_W'(d);
						count_char();
					end
				end
				default: begin
				end
			endcase
		end
	endtask

	// one accepted character transfer
	task automatic accept_char(input logic [CH_W-1:0] c, input logic f, input logic l);
		bit emitted;
		if (f) begin
			reset_scan();
		end
		if (scan_phase == PH_DONE) begin
			return;
		end
		take_char(c, emitted);
		if (emitted) begin
			return;
		end
		if (l) begin
			if (scan_phase == PH_WS || scan_phase == PH_SIGN) begin
				scan_radix = radix_reg;
				if (radix_invalid(scan_radix)) begin
					close_scan('0, '0, 1'b0);
					return;
				end
			end
			close_normal();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			radix_reg = RADIX_RESET;
			reset_scan();
			parsed_q.delete();
			mismatches = 0;
			fail_count   <= 0;
			open_results <= 0;
		end else begin
			// result transfer against the oldest prediction
			if (pop && !empty) begin
				if (parsed_q.size() == 0) begin
					$error("result with nothing pending: value %0d end_offset %0d",
						value, end_offset);
					mismatches++;
				end else begin
					want = parsed_q.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, actual %0d", $signed(want.value), value);
						mismatches++;
					end
					if (end_offset !== want.end_offset) begin
						$error("end_offset: expected %0d, actual %0d", want.end_offset,
							end_offset);
						mismatches++;
					end
					if (overflowed !== want.overflowed) begin
						$error("overflowed: expected %0d, actual %0d", want.overflowed,
							overflowed);
						mismatches++;
					end
				end
			end
			// register write
			if (psel && penable && pwrite && pready && paddr == ADDR_RADIX) begin
				radix_reg = pwdata[RADIX_W-1:0];
			end
			// character transfer
			if (push && !full) begin
				accept_char(ch, first, last);
			end
			fail_count   <= mismatches;
			open_results <= parsed_q.size();
		end
	end

endmodule

@@ dv/string_to_integer_parser_unit_tb.sv @@
// string_to_integer_parser_unit_tb: clock, reset, register writes and character strings
// for the parser; results are checked by s2i_result_checker
// depends on s2i_pkg, string_to_integer_parser_unit, s2i_result_checker
module string_to_integer_parser_unit_tb;
	import s2i_pkg::*;

	localparam int PHASE_ITEMS = 140;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [PDATA_W-1:0]        pwdata;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic [CH_W-1:0]           ch;
	logic                      first;
	logic                      last;
	logic                      push;
	logic                      full;
	logic signed [VALUE_W-1:0] value;
	logic [CNT_W-1:0]          end_offset;
	logic                      overflowed;
	logic                      empty;
	logic                      pop;
	int                        fail_count;
	int                        open_results;

	logic [CH_W-1:0] text_q[$];
	bit              quiet;
	int              items_sent;

	string_to_integer_parser_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.ch         (ch),
		.first      (first),
		.last       (last),
		.push       (push),
		.full       (full),
		.value      (value),
		.end_offset (end_offset),
		.overflowed (overflowed),
		.empty      (empty),
		.pop        (pop)
	);

	s2i_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.ch           (ch),
		.first        (first),
		.last         (last),
		.push         (push),
		.full         (full),
		.value        (value),
		.end_offset   (end_offset),
		.overflowed   (overflowed),
		.empty        (empty),
		.pop          (pop),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// one character transfer after a random gap
	task automatic send_char(input logic [CH_W-1:0] c, input logic f, input logic l);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ch    <= c;
		first <= f;
		last  <= l;
		push  <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic add_str(input string s);
		foreach (s[i]) begin
			text_q.push_back(s[i]);
		end
	endtask

	// send the collected text as one string
	task automatic send_text(input bit lead, input bit close);
		foreach (text_q[i]) begin
			send_char(text_q[i], lead && i == 0, close && i == text_q.size() - 1);
		end
		text_q.delete();
	endtask

	// drain all results and let the back end go idle
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		settle();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_RADIX;
		pwdata  <= PDATA_W'(r);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [CH_W-1:0] digit_char(input int d);
		if (d < 10) begin
			return CH_ZERO + CH_W'(d);
		end
		return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CH_W'(d - 10);
	endfunction

	// blanks, sign, prefix, digits and a stop character with random content
	task automatic build_number(input int radix_cfg, output bit close);
		logic [CH_W-1:0]    blanks[4];
		logic [CH_W-1:0]    digs[$];
		logic [VALUE_W-1:0] mag;
		int                 base;
		int                 n;
		blanks = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) text_q.push_back(blanks[$urandom_range(0, 3)]);
		case ($urandom_range(0, 3))
			1: text_q.push_back(CH_PLUS);
			2: text_q.push_back(CH_MINUS);
			default: begin
			end
		endcase
		base = radix_cfg;
		if (radix_cfg == int'(RADIX_AUTO)) begin
			case ($urandom_range(0, 3))
				0: begin
					add_str("0x");
					base = RADIX_HEX;
				end
				1: begin
					add_str("0X");
					base = RADIX_HEX;
				end
				2: begin
					text_q.push_back(CH_ZERO);
					base = RADIX_OCT;
				end
				default: base = RADIX_DEC;
			endcase
		end
		if (base < 2 || base > int'(RADIX_LIMIT)) begin
			base = RADIX_DEC;
		end
		// magnitude at the edge of the signed range, or plain random digits
		if ($urandom_range(0, 5) == 0) begin
			mag = ($urandom_range(0, 1) ? POS_MAX : NEG_MAG) + VALUE_W'($urandom_range(0, 2))
				- VALUE_W'(1);
			while (mag != 0) begin
				digs.push_front(digit_char(int'(mag % VALUE_W'(base))));
				mag = mag / VALUE_W'(base);
			end
		end else begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
			repeat (n) digs.push_back(digit_char($urandom_range(0, base - 1)));
		end
		foreach (digs[i]) begin
			text_q.push_back(digs[i]);
		end
		close = 1'b1;
		if ($urandom_range(0, 1)) begin
			text_q.push_back(CH_W'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 2)) text_q.push_back(CH_W'($urandom_range(0, 255)));
			close = $urandom_range(0, 1);
		end
		if (text_q.size() == 0) begin
			text_q.push_back(CH_W'($urandom_range(0, 255)));
		end
	endtask

	// result side: random stalls before each result transfer
	initial begin
		int stall;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		logic [RADIX_W-1:0] radix_plan[12];
		bit                 close;
		int                 stop_at;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		ch         = '0;
		first      = 1'b0;
		last       = 1'b0;
		push       = 1'b0;
		quiet      = 1'b0;
		items_sent = 0;
		radix_plan = '{RADIX_AUTO, RADIX_TWO, RADIX_LIMIT, RADIX_HEX, RADIX_OCT, RADIX_ONE,
			6'h3F, RADIX_LIMIT + 6'd1, RADIX_DEC, 6'd7, RADIX_AUTO, RADIX_AUTO};
		radix_plan[11] = RADIX_W'($urandom_range(0, 63));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decimal at reset radix: sign, no digits, nul, all ones, stop and ignore
		text_q.push_back(CH_TAB);
		add_str("-7");
		send_text(1, 1);
		add_str("+z");
		send_text(1, 1);
		text_q.push_back(8'h00);
		send_text(1, 1);
		text_q.push_back(8'hFF);
		send_text(1, 1);
		add_str("1 9");
		send_text(1, 1);
		text_q.push_back(CH_SPACE);
		text_q.push_back(CH_CR);
		text_q.push_back(CH_LF);
		send_text(1, 1);
		add_str("-");
		send_text(1, 1);
		// open string dropped by a new first
		add_str("42");
		send_text(1, 0);
		add_str("8");
		send_text(1, 1);

		// prefix detection
		set_radix(RADIX_AUTO);
		add_str("0x1F");
		send_text(1, 1);
		add_str("0xg");
		send_text(1, 1);
		add_str("017");
		send_text(1, 1);
		add_str("09");
		send_text(1, 1);
		add_str("0X");
		send_text(1, 1);

		// bad radix
		set_radix(RADIX_ONE);
		add_str("5");
		send_text(1, 1);

		// random strings over a sweep of radix settings
		foreach (radix_plan[p]) begin
			set_radix(radix_plan[p]);
			stop_at = items_sent + PHASE_ITEMS;
			while (items_sent < stop_at) begin
				if ($urandom_range(0, 29) == 0) begin
					quiet = !quiet;
				end
				case ($urandom_range(0, 9))
					0: begin
						// noise with random markers
						repeat ($urandom_range(1, 5)) begin
							send_char(CH_W'($urandom_range(0, 255)), $urandom_range(0, 1),
								$urandom_range(0, 1));
						end
					end
					1: begin
						// broken: no start marker, or never closed
						build_number(radix_plan[p], close);
						if ($urandom_range(0, 1)) begin
							send_text(0, close);
						end else begin
							send_text(1, 0);
						end
					end
					default: begin
						build_number(radix_plan[p], close);
						send_text(1, close);
					end
				endcase
			end
		end
		quiet = 1'b0;

		settle();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ string_to_integer_parser_unit.f @@
src/s2i_pkg.sv
src/s2i_front.sv
src/s2i_back.sv
src/string_to_integer_parser_unit.sv
src/s2i_checker.sv
dv/s2i_result_checker.sv
dv/string_to_integer_parser_unit_tb.sv
